[design/mcdp_pkg.sv]
// ----------------------------------------------------------------------------
// mcdp_pkg
// shared widths and control word field positions for the microcycle datapath
// ----------------------------------------------------------------------------
package mcdp_pkg;

    localparam int CW_BITS = 35;

    // control word bit positions
    localparam int CW_IRD      = 34;
    localparam int CW_COND_HI  = 33;
    localparam int CW_J_HI     = 31;
    localparam int CW_LD_MAR   = 25;
    localparam int CW_LD_MDR   = 24;
    localparam int CW_LD_IR    = 23;
    localparam int CW_LD_BEN   = 22;
    localparam int CW_LD_REG   = 21;
    localparam int CW_LD_CC    = 20;
    localparam int CW_LD_PC    = 19;
    localparam int CW_GATE_PC  = 18;
    localparam int CW_GATE_MDR = 17;
    localparam int CW_GATE_ALU = 16;
    localparam int CW_GATE_MM  = 15;
    localparam int CW_GATE_SHF = 14;
    localparam int CW_PCMUX_HI = 13;
    localparam int CW_DRMUX    = 11;
    localparam int CW_SR1MUX   = 10;
    localparam int CW_ADDR1MUX = 9;
    localparam int CW_ADDR2_HI = 8;
    localparam int CW_MARMUX   = 6;
    localparam int CW_ALUK_HI  = 5;
    localparam int CW_MIO_EN   = 3;
    localparam int CW_R_W      = 2;
    localparam int CW_DSIZE    = 1;
    localparam int CW_LSHF1    = 0;

    localparam logic [1:0] COND_READY  = 2'd1;
    localparam logic [1:0] COND_BRANCH = 2'd2;
    localparam logic [1:0] COND_ADDR   = 2'd3;

    localparam logic [1:0] ALU_ADD  = 2'd0;
    localparam logic [1:0] ALU_AND  = 2'd1;
    localparam logic [1:0] ALU_XOR  = 2'd2;

    localparam logic [1:0] SHF_RSHL = 2'd1;
    localparam logic [1:0] SHF_RSHA = 2'd3;

    localparam logic [1:0] PC_INC = 2'd0;
    localparam logic [1:0] PC_BUS = 2'd1;

    localparam logic [2:0] NZP_RESET = 3'b010;

    // architectural state visible to the datapath logic
    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] ir;
        logic [15:0] mar;
        logic [15:0] mdr;
        logic [2:0]  nzp;
        logic        ben;
        logic        rdy;
    } arch_t;

    // update commands from the datapath to the state block
    typedef struct packed {
        logic        ld_reg;
        logic [2:0]  dr;
        logic        ld_pc;
        logic [15:0] pc;
        logic        ld_ir;
        logic        ld_mar;
        logic        ld_mdr;
        logic [15:0] mdr;
        logic        ld_cc;
        logic [2:0]  nzp;
        logic        ld_ben;
        logic        ben;
        logic        rdy;
        logic [15:0] bus;
    } upd_t;

endpackage

[design/mcdp_state.sv]
// ----------------------------------------------------------------------------
// mcdp_state
// register file and architectural registers, loaded once per accepted beat
// ----------------------------------------------------------------------------
module mcdp_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                step,
    input  mcdp_pkg::upd_t      upd,
    output mcdp_pkg::arch_t     arch,
    output logic [7:0][15:0]    regs
);

    mcdp_pkg::arch_t  arch_reg;
    logic [7:0][15:0] rf_reg;

    assign arch = arch_reg;
    assign regs = rf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arch_reg.pc  <= '0;
            arch_reg.ir  <= '0;
            arch_reg.mar <= '0;
            arch_reg.mdr <= '0;
            arch_reg.nzp <= mcdp_pkg::NZP_RESET;
            arch_reg.ben <= 1'b0;
            arch_reg.rdy <= 1'b0;
            rf_reg       <= '0;
        end
        else if (cfg_we)
        begin
            arch_reg.pc <= cfg_wdata;
        end
        else if (step)
        begin
            if (upd.ld_reg) rf_reg[upd.dr] <= upd.bus;
            if (upd.ld_pc)  arch_reg.pc <= upd.pc;
            if (upd.ld_ir)  arch_reg.ir <= upd.bus;
            if (upd.ld_mar) arch_reg.mar <= upd.bus;
            if (upd.ld_mdr) arch_reg.mdr <= upd.mdr;
            if (upd.ld_cc)  arch_reg.nzp <= upd.nzp;
            if (upd.ld_ben) arch_reg.ben <= upd.ben;
            arch_reg.rdy <= upd.rdy;
        end
    end

endmodule

[design/mcdp_datapath.sv]
// ----------------------------------------------------------------------------
// mcdp_datapath
// bus sources, gate priority, microsequencer and state update decode
// ----------------------------------------------------------------------------
module mcdp_datapath (
    input  logic [34:0]       cw,
    input  logic [15:0]       rdata,
    input  logic              rdy_next,
    input  mcdp_pkg::arch_t   arch,
    input  logic [7:0][15:0]  regs,
    output mcdp_pkg::upd_t    upd,
    output logic [5:0]        ns,
    output logic [1:0]        be
);

    logic [15:0] ir, sr1, sr2, a1, a2, adder, marmux, alu, shf, mdrg, bus;
    logic [2:0]  sr1idx;
    logic [1:0]  cond;
    logic [3:0]  amt;
    logic        mio, word, mar0;
    logic [15:0] sra_fill;

    always_comb
    begin
        ir   = arch.ir;
        mio  = cw[mcdp_pkg::CW_MIO_EN];
        word = cw[mcdp_pkg::CW_DSIZE];
        mar0 = arch.mar[0];
        cond = cw[mcdp_pkg::CW_COND_HI -: 2];

        // microsequencer
        if (cw[mcdp_pkg::CW_IRD])
            ns = {2'b00, ir[15:12]};
        else
        begin
            ns = cw[mcdp_pkg::CW_J_HI -: 6];
            case (cond)
                mcdp_pkg::COND_READY:  ns[1] = ns[1] | arch.rdy;
                mcdp_pkg::COND_BRANCH: ns[2] = ns[2] | arch.ben;
                mcdp_pkg::COND_ADDR:   ns[0] = ns[0] | ir[11];
                default: ;
            endcase
        end

        // address adder
        sr1idx = cw[mcdp_pkg::CW_SR1MUX] ? ir[8:6] : ir[11:9];
        sr1    = regs[sr1idx];
        case (cw[mcdp_pkg::CW_ADDR2_HI -: 2])
            2'd0:    a2 = '0;
            2'd1:    a2 = {{10{ir[5]}}, ir[5:0]};
            2'd2:    a2 = {{7{ir[8]}}, ir[8:0]};
            default: a2 = {{5{ir[10]}}, ir[10:0]};
        endcase
        if (cw[mcdp_pkg::CW_LSHF1]) a2 = {a2[14:0], 1'b0};
        a1     = cw[mcdp_pkg::CW_ADDR1MUX] ? sr1 : arch.pc;
        adder  = a1 + a2;
        marmux = cw[mcdp_pkg::CW_MARMUX] ? adder : {7'd0, ir[7:0], 1'b0};

        // alu
        sr2 = ir[5] ? {{11{ir[4]}}, ir[4:0]} : regs[ir[2:0]];
        case (cw[mcdp_pkg::CW_ALUK_HI -: 2])
            mcdp_pkg::ALU_ADD: alu = sr1 + sr2;
            mcdp_pkg::ALU_AND: alu = sr1 & sr2;
            mcdp_pkg::ALU_XOR: alu = sr1 ^ sr2;
            default:           alu = sr1;
        endcase

        // shifter
        amt      = ir[3:0];
        sra_fill = sr1[15] ? ~(16'hFFFF >> amt) : 16'h0000;
        case (ir[5:4])
            mcdp_pkg::SHF_RSHL: shf = sr1 >> amt;
            mcdp_pkg::SHF_RSHA: shf = (sr1 >> amt) | sra_fill;
            default:            shf = sr1 << amt;
        endcase

        // mdr gate
        if (word)
            mdrg = arch.mdr;
        else if (mar0)
            mdrg = {{8{arch.mdr[15]}}, arch.mdr[15:8]};
        else
            mdrg = {{8{arch.mdr[7]}}, arch.mdr[7:0]};

        if (cw[mcdp_pkg::CW_GATE_ALU])      bus = alu;
        else if (cw[mcdp_pkg::CW_GATE_MM])  bus = marmux;
        else if (cw[mcdp_pkg::CW_GATE_PC])  bus = arch.pc;
        else if (cw[mcdp_pkg::CW_GATE_SHF]) bus = shf;
        else if (cw[mcdp_pkg::CW_GATE_MDR]) bus = mdrg;
        else                                bus = '0;

        be = mio ? (word ? 2'b11 : (mar0 ? 2'b10 : 2'b01)) : 2'b00;

        // state updates
        upd.bus    = bus;
        upd.ld_reg = cw[mcdp_pkg::CW_LD_REG];
        upd.dr     = cw[mcdp_pkg::CW_DRMUX] ? 3'd7 : ir[11:9];
        upd.ld_pc  = cw[mcdp_pkg::CW_LD_PC];
        case (cw[mcdp_pkg::CW_PCMUX_HI -: 2])
            mcdp_pkg::PC_INC: upd.pc = arch.pc + 16'd2;
            mcdp_pkg::PC_BUS: upd.pc = bus;
            default:          upd.pc = adder;
        endcase
        upd.ld_ir  = cw[mcdp_pkg::CW_LD_IR];
        upd.ld_mar = cw[mcdp_pkg::CW_LD_MAR];
        upd.ld_mdr = cw[mcdp_pkg::CW_LD_MDR];
        if (mio)       upd.mdr = rdata;
        else if (word) upd.mdr = bus;
        else           upd.mdr = {bus[7:0], bus[7:0]};
        upd.ld_cc  = cw[mcdp_pkg::CW_LD_CC];
        if (bus == 16'd0)  upd.nzp = 3'b010;
        else if (bus[15])  upd.nzp = 3'b100;
        else               upd.nzp = 3'b001;
        upd.ld_ben = cw[mcdp_pkg::CW_LD_BEN];
        upd.ben    = (ir[11] & arch.nzp[2]) | (ir[10] & arch.nzp[1]) |
                     (ir[9] & arch.nzp[0]);
        upd.rdy    = mio & rdy_next;
    end

endmodule

[design/microcoded_cpu_datapath_step_core.sv]
// ----------------------------------------------------------------------------
// microcoded_cpu_datapath_step_core
// one microcycle of a 16-bit microcoded cpu per input beat
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry control_word, mem_rdata and
//   mem_ready_next; one beat is one microcycle
//   output channel: out_valid / out_stall carry next_state, bus value, the
//   memory request (enable, write, byte enables, word address, write data)
//   and the pc after the update
//   config: cfg_we with cfg_wdata loads the pc at once
// timing
//   the datapath is combinational from the architectural registers and the
//   input beat into a result register; one beat per cycle sustained while
//   out_stall is low; state update and result capture happen on the same edge
// reset
//   registers clear, nzp = zero flag, pc = 0, result register empty
// stall
//   the result register holds while out_stall is high; a new beat is still
//   taken when the result register drains on that same edge
// ----------------------------------------------------------------------------
module microcoded_cpu_datapath_step_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [34:0] control_word,
    input  logic [15:0] mem_rdata,
    input  logic        mem_ready_next,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  next_state,
    output logic [15:0] bus_value,
    output logic        mem_enable,
    output logic        mem_write,
    output logic [1:0]  mem_byte_enable,
    output logic [14:0] mem_word_address,
    output logic [15:0] mem_wdata,
    output logic [15:0] pc_value
);

    mcdp_pkg::arch_t  arch;
    mcdp_pkg::upd_t   upd;
    logic [7:0][15:0] regs;
    logic [5:0]       ns;
    logic [1:0]       be;
    logic             step;
    logic             out_valid_reg;
    logic [15:0]      pc_after;

    // accept whenever the result slot is empty or draining this edge
    assign in_stall = out_valid_reg & out_stall;
    assign step     = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    mcdp_datapath u_dp (
        .cw       (control_word),
        .rdata    (mem_rdata),
        .rdy_next (mem_ready_next),
        .arch     (arch),
        .regs     (regs),
        .upd      (upd),
        .ns       (ns),
        .be       (be)
    );

    mcdp_state u_st (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .upd       (upd),
        .arch      (arch),
        .regs      (regs)
    );

    assign pc_after = upd.ld_pc ? upd.pc : arch.pc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            next_state       <= ns;
            bus_value        <= upd.bus;
            mem_enable       <= control_word[mcdp_pkg::CW_MIO_EN];
            mem_write        <= control_word[mcdp_pkg::CW_MIO_EN] &
                                control_word[mcdp_pkg::CW_R_W];
            mem_byte_enable  <= be;
            mem_word_address <= arch.mar[15:1];
            mem_wdata        <= arch.mdr;
            pc_value         <= pc_after;
        end
    end

endmodule
